// File: rtl/core/ovfd_pkg.sv
`default_nettype none

package ovfd_pkg;

    // Fixed field widths
    localparam int VOTES_W    = 16;
    localparam int FIELD_MAPS = VOTES_W / 2;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd2;

    // Register reset values
    localparam logic [3:0]       MAP_COUNT_RST = 4'd1;
    localparam logic [CFG_W-1:0] DIM_RST       = 11'd1024;

    // Cell states
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_OBJECT  = 2'd2;
    localparam logic [1:0] ST_TEMP    = 2'd3;

    // One lane's decoded vote
    typedef struct packed {
        logic obj;
        logic emp;
        logic tmp;
    } vote_hits_t;

endpackage

`default_nettype wire

// File: rtl/core/ovfd_lane.sv
`default_nettype none

// Decodes one map's state into a vote with at most one bit set.
module ovfd_lane (
    input  wire logic               en,
    input  wire logic [1:0]         state,
    output ovfd_pkg::vote_hits_t    hits
);

    always_comb begin
        hits.obj = en && (state == ovfd_pkg::ST_OBJECT);
        hits.emp = en && (state == ovfd_pkg::ST_EMPTY);
        hits.tmp = en && (state == ovfd_pkg::ST_TEMP);
    end

endmodule

`default_nettype wire

// File: rtl/core/ovfd_merge.sv
`default_nettype none

// Counts the lanes' votes and applies the fusion rule.
module ovfd_merge #(
    parameter int LANES = 8
) (
    input  wire ovfd_pkg::vote_hits_t [LANES-1:0] hits,
    output logic [1:0]                            fused_state
);

    localparam int CNT_W = $clog2(LANES + 1);

    logic [CNT_W-1:0] n_obj;
    logic [CNT_W-1:0] n_emp;
    logic [CNT_W-1:0] n_tmp;

    always_comb begin
        n_obj = '0;
        n_emp = '0;
        n_tmp = '0;
        for (int k = 0; k < LANES; k++) begin
            n_obj = n_obj + CNT_W'(hits[k].obj);
            n_emp = n_emp + CNT_W'(hits[k].emp);
            n_tmp = n_tmp + CNT_W'(hits[k].tmp);
        end
    end

    always_comb begin
        if (n_tmp <= CNT_W'(1)) begin
            if (n_obj < n_emp) begin
                fused_state = ovfd_pkg::ST_EMPTY;
            end else if (n_obj != '0) begin
                fused_state = ovfd_pkg::ST_OBJECT;
            end else begin
                fused_state = ovfd_pkg::ST_UNKNOWN;
            end
        end else if (n_obj < n_emp) begin
            fused_state = (n_tmp <= n_emp) ? ovfd_pkg::ST_EMPTY : ovfd_pkg::ST_TEMP;
        end else begin
            fused_state = ovfd_pkg::ST_OBJECT;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ovfd_window.sv
`default_nettype none

// Object-bit line store (rows r-1 and r-2 packed per column) plus the 3x3
// window registers. Read on accept, written when the item retires.
module ovfd_window #(
    parameter int DIM    = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              cur_obj,
    input  wire logic              rule_en,
    output logic                   mark
);

    // bit 1: row r-2, bit 0: row r-1
    logic [1:0] line_mem [DIM];
    logic [1:0] rd_data_reg;

    logic p1m1_reg, p1m2_reg, p2m1_reg, p2m2_reg;
    logic cm1_reg, cm2_reg;
    logic p1c, p2c;
    logic [1:0] wr_data;

    assign p1c     = rd_data_reg[0];
    assign p2c     = rd_data_reg[1];
    assign wr_data = {p1c, cur_obj};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            // one-column frames read the entry being retired this cycle
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= line_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1m1_reg <= 1'b0;
            p1m2_reg <= 1'b0;
            p2m1_reg <= 1'b0;
            p2m2_reg <= 1'b0;
            cm1_reg  <= 1'b0;
            cm2_reg  <= 1'b0;
        end else if (wr_en) begin
            p1m1_reg <= p1c;
            p1m2_reg <= p1m1_reg;
            p2m1_reg <= p2c;
            p2m2_reg <= p2m1_reg;
            cm1_reg  <= cur_obj;
            cm2_reg  <= cm1_reg;
        end
    end

    assign mark = rule_en && !p1m1_reg &&
                  (p1m2_reg | p1c | p2m2_reg | p2m1_reg | p2c | cm2_reg | cm1_reg | cur_obj);

endmodule

`default_nettype wire

// File: rtl/core/occupancy_vote_fusion_dilate.sv
`default_nettype none

// Occupancy grid vote fusion with temp-object dilation.
// Input channel (s_valid/s_ready/s_cell_votes): one grid cell per request in
// raster order, map k's 2-bit state in bits 2k+1:2k.
// Result channel (m_valid/m_ready/m_*): one result per input request: the
// cell's row and column, its fused state, and a flag that the cell one row up
// and one column left becomes temp object.
// Config port: cfg_wr_en/cfg_index/cfg_wr_data. The user must write it only
// while no request is in flight; the block does not enforce it. Index 0
// map_count, 1 grid_rows, 2 grid_cols. Requests pass the fuse stage, then the
// result register, to m_*. Throughput: one request per cycle; the line store is
// a single memory read at accept and written when the cell retires, with
// write-to-read bypass. Receiver stall: the result register holds; the fuse
// stage holds one more cell, after which s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous): pipeline empties, raster position goes to
// row 0 column 0, window bits clear, registers return to map_count 1 and a
// 1024 x 1024 frame. Line store contents are not cleared; each entry is
// written one row before it is read.
module occupancy_vote_fusion_dilate #(
    parameter int MAX_MAPS = 8,
    parameter int MAX_DIM  = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config
    input  wire logic                              cfg_wr_en,
    input  wire logic [ovfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ovfd_pkg::CFG_W-1:0]        cfg_wr_data,
    // input cells
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ovfd_pkg::VOTES_W-1:0]      s_cell_votes,
    // results
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [ovfd_pkg::POS_W-1:0]             m_cell_row,
    output logic [ovfd_pkg::POS_W-1:0]             m_cell_col,
    output logic [1:0]                             m_fused_state,
    output logic                                   m_mark_center_temp
);

    localparam int ADDR_W = $clog2(MAX_DIM);
    // wide enough for both the config field and MAX_DIM itself
    localparam int CW     = (ADDR_W + 1 > ovfd_pkg::CFG_W) ? ADDR_W + 1 : ovfd_pkg::CFG_W;
    localparam int MC_W   = 5;

    // ---------------- configuration registers ----------------
    logic [3:0]                 map_count_reg;
    logic [ovfd_pkg::CFG_W-1:0] grid_rows_reg;
    logic [ovfd_pkg::CFG_W-1:0] grid_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_count_reg <= ovfd_pkg::MAP_COUNT_RST;
            grid_rows_reg <= ovfd_pkg::DIM_RST;
            grid_cols_reg <= ovfd_pkg::DIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ovfd_pkg::CFG_MAP_COUNT: map_count_reg <= cfg_wr_data[3:0];
                ovfd_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_wr_data;
                ovfd_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Last valid index per dimension: zero means one, clamp at MAX_DIM.
    logic [CW-1:0]     rows_ext, cols_ext;
    logic [ADDR_W-1:0] row_last, col_last;

    assign rows_ext = CW'(grid_rows_reg);
    assign cols_ext = CW'(grid_cols_reg);

    always_comb begin
        if (rows_ext == '0) begin
            row_last = '0;
        end else if (rows_ext > CW'(MAX_DIM)) begin
            row_last = ADDR_W'(MAX_DIM - 1);
        end else begin
            row_last = ADDR_W'(rows_ext - CW'(1));
        end
        if (cols_ext == '0) begin
            col_last = '0;
        end else if (cols_ext > CW'(MAX_DIM)) begin
            col_last = ADDR_W'(MAX_DIM - 1);
        end else begin
            col_last = ADDR_W'(cols_ext - CW'(1));
        end
    end

    // ---------------- handshake / pipeline control ----------------
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg;
    logic s_accept, fire;

    assign fire     = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || fire;
    assign s_accept = s_valid && s_ready;
    assign s1_valid_next = s_accept || (s1_valid_reg && !fire);

    // ---------------- raster position ----------------
    logic [ADDR_W-1:0] row_cnt_reg, row_cnt_next;
    logic [ADDR_W-1:0] col_cnt_reg, col_cnt_next;

    always_comb begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (s_accept) begin
            if (col_cnt_reg >= col_last) begin
                col_cnt_next = '0;
                row_cnt_next = (row_cnt_reg >= row_last) ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- fuse stage registers ----------------
    logic [ovfd_pkg::VOTES_W-1:0] s1_votes_reg;
    logic [ADDR_W-1:0]            s1_row_reg, s1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= fire || (m_valid_reg && !m_ready);
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_votes_reg <= s_cell_votes;
            s1_row_reg   <= row_cnt_reg;
            s1_col_reg   <= col_cnt_reg;
        end
    end

    // ---------------- vote lanes ----------------
    logic [MC_W-1:0]                     map_count_ext;
    ovfd_pkg::vote_hits_t [MAX_MAPS-1:0] lane_hits;
    logic [1:0]                          fused_state;

    assign map_count_ext = MC_W'(map_count_reg);

    for (genvar k = 0; k < MAX_MAPS; k++) begin : g_lane
        logic [1:0] lane_state;
        if (k < ovfd_pkg::FIELD_MAPS) begin : g_field
            assign lane_state = s1_votes_reg[2*k +: 2];
        end else begin : g_none
            // maps past the input field vote unknown
            assign lane_state = ovfd_pkg::ST_UNKNOWN;
        end
        ovfd_lane u_lane (
            .en    (MC_W'(k) < map_count_ext),
            .state (lane_state),
            .hits  (lane_hits[k])
        );
    end

    ovfd_merge #(
        .LANES (MAX_MAPS)
    ) u_merge (
        .hits        (lane_hits),
        .fused_state (fused_state)
    );

    // ---------------- dilation window ----------------
    logic cur_obj, rule_en, mark;

    assign cur_obj = (fused_state == ovfd_pkg::ST_OBJECT);
    assign rule_en = (s1_row_reg >= ADDR_W'(2)) && (s1_col_reg >= ADDR_W'(2));

    ovfd_window #(
        .DIM    (MAX_DIM),
        .ADDR_W (ADDR_W)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (col_cnt_reg),
        .wr_en   (fire),
        .wr_addr (s1_col_reg),
        .cur_obj (cur_obj),
        .rule_en (rule_en),
        .mark    (mark)
    );

    // ---------------- result register ----------------
    logic [ovfd_pkg::POS_W-1:0] m_row_reg, m_col_reg;
    logic [1:0]                 m_state_reg;
    logic                       m_mark_reg;

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_row_reg   <= ovfd_pkg::POS_W'(s1_row_reg);
            m_col_reg   <= ovfd_pkg::POS_W'(s1_col_reg);
            m_state_reg <= fused_state;
            m_mark_reg  <= mark;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_cell_row         = m_row_reg;
    assign m_cell_col         = m_col_reg;
    assign m_fused_state      = m_state_reg;
    assign m_mark_center_temp = m_mark_reg;

`ifndef ASSERT_OFF
    // a held cell in the fuse stage is never dropped
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !fire |=> s1_valid_reg)
        else $error("fuse stage lost a cell");

    // a retired cell always lands in the result register
    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("retired cell missing from result register");

    // column wraps at the last column of the frame
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (col_cnt_reg >= col_last) |=> col_cnt_reg == '0)
        else $error("column counter did not wrap");

    // mark only in the frame interior
    a_mark_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && mark |-> (s1_row_reg >= ADDR_W'(2)) && (s1_col_reg >= ADDR_W'(2)))
        else $error("mark raised at frame border");
`endif

endmodule

`default_nettype wire
